FILE: rtl/prdfd_pkg.sv
// Package: shared types and constants of the pixel-run delta frame decoder.
package prdfd_pkg;

   // Command codes
   localparam logic [1:0] CMD_BYTE   = 2'd0;
   localparam logic [1:0] CMD_REWIND = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // Response status codes
   localparam logic [2:0] ST_TAKEN = 3'd0;
   localparam logic [2:0] ST_FRAME = 3'd1;
   localparam logic [2:0] ST_ERROR = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_IDLE  = 3'd4;

   // Error codes
   localparam logic [2:0] ERR_NONE    = 3'd0;
   localparam logic [2:0] ERR_HEADER  = 3'd1;
   localparam logic [2:0] ERR_SMALL   = 3'd2;
   localparam logic [2:0] ERR_RUNHDR  = 3'd3;
   localparam logic [2:0] ERR_BEYOND  = 3'd4;
   localparam logic [2:0] ERR_OVERRUN = 3'd5;

   // Parser phases
   localparam logic [2:0] PH_HEADER   = 3'd0;
   localparam logic [2:0] PH_REC_SIZE = 3'd1;
   localparam logic [2:0] PH_RUN_CNT  = 3'd2;
   localparam logic [2:0] PH_RUN_HDR  = 3'd3;
   localparam logic [2:0] PH_PIXELS   = 3'd4;
   localparam logic [2:0] PH_SKIP     = 3'd5;
   localparam logic [2:0] PH_DONE     = 3'd6;

   // Magic byte of the header at a given position
   function automatic logic [7:0] magic_byte(input logic [2:0] pos);
      logic [7:0] val;
      case (pos)
         3'd0:    val = 8'h4E;
         3'd1:    val = 8'h42;
         3'd2:    val = 8'h54;
         3'd3:    val = 8'h49;
         3'd4:    val = 8'h54;
         3'd5:    val = 8'h4C;
         3'd6:    val = 8'h45;
         default: val = 8'h31;
      endcase
      return val;
   endfunction

   // Scale an 8-bit channel by level/15
   function automatic logic [7:0] scale_channel(input logic [7:0] chan, input logic [3:0] level);
      logic [11:0] prod;
      logic [27:0] quot;
      prod = 12'(chan) * 12'(level);
      // multiply by 2^19/15 rounded up, then drop 19 bits (exact for prod < 3840)
      quot = {16'd0, prod} * 28'd34953;
      return quot[26:19];
   endfunction

   // Write request from the parser to the pixel store
   typedef struct packed {
      logic        wr_en;
      logic [15:0] wr_addr;
      logic [15:0] wr_data;
   } store_write_type;

endpackage

FILE: rtl/prdfd_store.sv
// Pixel store: one synchronous RAM with a clearing sweep and a registered read.
module prdfd_store
   import prdfd_pkg::*;
#(
   parameter int PIXEL_COUNT = 57344,
   parameter int ADDR_W = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            clear_start,
   output logic            clear_busy,
   input  store_write_type wr,
   input  logic [15:0]     rd_addr,
   output logic [15:0]     rd_data
);

   logic [15:0]       mem [PIXEL_COUNT];
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              busy_ff, busy_in;
   logic [15:0]       rd_ff;
   logic              rd_ok_ff;

   // Advance the clearing sweep
   always_comb begin
      sweep_in = sweep_ff;
      busy_in  = busy_ff;
      if (clear_start) begin
         sweep_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (sweep_ff == ADDR_W'(PIXEL_COUNT - 1)) busy_in = 1'b0;
         sweep_in = sweep_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         busy_ff  <= 1'b1;
      end else begin
         sweep_ff <= sweep_in;
         busy_ff  <= busy_in;
      end
   end

   // Write port: clear sweep or parser write; registered read
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[sweep_ff] <= '0;
      end else if (wr.wr_en && wr.wr_addr < 16'(PIXEL_COUNT)) begin
         mem[wr.wr_addr[ADDR_W-1:0]] <= wr.wr_data;
      end
      rd_ok_ff <= rd_addr < 16'(PIXEL_COUNT);
      rd_ff    <= mem[rd_addr[ADDR_W-1:0]];
   end

   assign rd_data    = rd_ok_ff ? rd_ff : 16'd0;
   assign clear_busy = busy_ff;

endmodule

FILE: rtl/prdfd_parser.sv
// Stream parser: header checks, record and run decoding, pixel write requests.
module prdfd_parser
   import prdfd_pkg::*;
#(
   parameter int FRAME_WIDTH = 256,
   parameter int FRAME_HEIGHT = 224,
   parameter int HEADER_BYTES = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            clear,
   input  logic            byte_en,
   input  logic [7:0]      data_byte,
   output logic [2:0]      status,
   output logic [2:0]      error_code,
   output logic [31:0]     frame_number,
   output store_write_type wr
);

   localparam logic [32:0] PIXEL_COUNT = 33'(FRAME_WIDTH * FRAME_HEIGHT);

   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] runs_ff, runs_in;
   logic [15:0] rpos_ff, rpos_in;
   logic [15:0] rleft_ff, rleft_in;
   logic [31:0] frames_ff, frames_in;
   logic [31:0] total_ff, total_in;
   logic [2:0]  err_ff, err_in;
   logic [2:0]  st;
   logic [31:0] word;
   logic [31:0] frames_inc;
   logic [16:0] len2;
   logic        ok;

   assign word       = shift_ff | ({24'd0, data_byte} << {pos_ff[1:0], 3'b000});
   assign frames_inc = frames_ff + 32'd1;
   assign len2       = {word[31:16], 1'b0};

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      shift_in  = shift_ff;
      left_in   = left_ff;
      runs_in   = runs_ff;
      rpos_in   = rpos_ff;
      rleft_in  = rleft_ff;
      frames_in = frames_ff;
      total_in  = total_ff;
      err_in    = err_ff;
      st        = ST_TAKEN;
      ok        = 1'b1;
      wr        = '0;
      wr.wr_addr = rpos_ff;
      wr.wr_data = {data_byte, shift_ff[7:0]};
      if (byte_en) begin
         if (err_ff != ERR_NONE) begin
            st = ST_ERROR;
         end else begin
            case (phase_ff)
               PH_HEADER: begin
                  if (pos_ff < 6'd8) begin
                     ok = data_byte == magic_byte(pos_ff[2:0]);
                  end else if (pos_ff < 6'd32) begin
                     shift_in = word;
                     if (pos_ff[1:0] == 2'd3) begin
                        if (pos_ff == 6'd11)      ok = word == 32'd1;
                        else if (pos_ff == 6'd15) ok = word == 32'(FRAME_WIDTH);
                        else if (pos_ff == 6'd19) ok = word == 32'(FRAME_HEIGHT);
                        else                      ok = word != 32'd0;
                        if (pos_ff == 6'd31) total_in = word;
                        shift_in = '0;
                     end
                  end
                  if (!ok) begin
                     err_in = ERR_HEADER;
                     st     = ST_ERROR;
                  end else if (pos_ff >= 6'd31 && 7'(pos_ff) + 7'd1 >= 7'(HEADER_BYTES)) begin
                     phase_in = PH_REC_SIZE;
                     pos_in   = '0;
                     shift_in = '0;
                  end else begin
                     pos_in = pos_ff + 6'd1;
                  end
               end
               PH_REC_SIZE, PH_RUN_CNT, PH_RUN_HDR: begin
                  shift_in = word;
                  pos_in   = {4'd0, pos_ff[1:0]} + 6'd1;
                  if (pos_ff[1:0] == 2'd3) begin
                     pos_in   = '0;
                     shift_in = '0;
                     if (phase_ff == PH_REC_SIZE) begin
                        if (word < 32'd4) begin
                           err_in = ERR_SMALL;
                           st     = ST_ERROR;
                        end else begin
                           left_in  = word - 32'd4;
                           phase_in = PH_RUN_CNT;
                        end
                     end else if (phase_ff == PH_RUN_CNT) begin
                        runs_in = word;
                        // decide next unit
                        if (word != 32'd0) begin
                           if (left_ff < 32'd4) begin
                              err_in = ERR_RUNHDR;
                              st     = ST_ERROR;
                           end else begin
                              left_in  = left_ff - 32'd4;
                              phase_in = PH_RUN_HDR;
                           end
                        end else if (left_ff != 32'd0) begin
                           phase_in = PH_SKIP;
                        end else begin
                           frames_in = frames_inc;
                           phase_in  = (frames_inc >= total_ff) ? PH_DONE : PH_REC_SIZE;
                           st        = ST_FRAME;
                        end
                     end else begin
                        runs_in = runs_ff - 32'd1;
                        if (33'(word[15:0]) + 33'(word[31:16]) > PIXEL_COUNT) begin
                           err_in = ERR_BEYOND;
                           st     = ST_ERROR;
                        end else if (32'(len2) > left_ff) begin
                           err_in = ERR_OVERRUN;
                           st     = ST_ERROR;
                        end else if (word[31:16] != 16'd0) begin
                           left_in  = left_ff - 32'(len2);
                           rpos_in  = word[15:0];
                           rleft_in = word[31:16];
                           phase_in = PH_PIXELS;
                        end else if (runs_ff != 32'd1) begin
                           if (left_ff < 32'd4) begin
                              err_in = ERR_RUNHDR;
                              st     = ST_ERROR;
                           end else begin
                              left_in  = left_ff - 32'd4;
                              phase_in = PH_RUN_HDR;
                           end
                        end else if (left_ff != 32'd0) begin
                           phase_in = PH_SKIP;
                        end else begin
                           frames_in = frames_inc;
                           phase_in  = (frames_inc >= total_ff) ? PH_DONE : PH_REC_SIZE;
                           st        = ST_FRAME;
                        end
                     end
                  end
               end
               PH_PIXELS: begin
                  if (!pos_ff[0]) begin
                     shift_in = {24'd0, data_byte};
                     pos_in   = 6'd1;
                  end else begin
                     wr.wr_en = 1'b1;
                     rpos_in  = rpos_ff + 16'd1;
                     rleft_in = rleft_ff - 16'd1;
                     pos_in   = '0;
                     shift_in = '0;
                     if (rleft_ff == 16'd1) begin
                        if (runs_ff != 32'd0) begin
                           if (left_ff < 32'd4) begin
                              err_in = ERR_RUNHDR;
                              st     = ST_ERROR;
                           end else begin
                              left_in  = left_ff - 32'd4;
                              phase_in = PH_RUN_HDR;
                           end
                        end else if (left_ff != 32'd0) begin
                           phase_in = PH_SKIP;
                        end else begin
                           frames_in = frames_inc;
                           phase_in  = (frames_inc >= total_ff) ? PH_DONE : PH_REC_SIZE;
                           st        = ST_FRAME;
                        end
                     end
                  end
               end
               PH_SKIP: begin
                  left_in = (left_ff != 32'd0) ? left_ff - 32'd1 : left_ff;
                  if (left_ff <= 32'd1) begin
                     frames_in = frames_inc;
                     pos_in    = '0;
                     shift_in  = '0;
                     phase_in  = (frames_inc >= total_ff) ? PH_DONE : PH_REC_SIZE;
                     st        = ST_FRAME;
                  end
               end
               default: st = ST_IDLE;
            endcase
         end
      end
   end

   // Hold parser state; rewind and reset clear it
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= '0;
         shift_ff  <= '0;
         left_ff   <= '0;
         runs_ff   <= '0;
         rpos_ff   <= '0;
         rleft_ff  <= '0;
         frames_ff <= '0;
         total_ff  <= '0;
         err_ff    <= ERR_NONE;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         shift_ff  <= shift_in;
         left_ff   <= left_in;
         runs_ff   <= runs_in;
         rpos_ff   <= rpos_in;
         rleft_ff  <= rleft_in;
         frames_ff <= frames_in;
         total_ff  <= total_in;
         err_ff    <= err_in;
      end
   end

   assign status       = st;
   assign error_code   = err_in;
   assign frame_number = frames_in;

endmodule

FILE: rtl/pixel_run_delta_frame_decoder_top.sv
// Top level of the pixel-run delta frame decoder.
// One request is taken per cycle when the response register is free and
// no read or store clearing is pending. A pixel read is registered in the
// store, then in the response register. After reset and every rewind a
// sweep clears all FRAME_WIDTH*FRAME_HEIGHT pixels; no request is taken.
module pixel_run_delta_frame_decoder_top
   import prdfd_pkg::*;
#(
   parameter int FRAME_WIDTH = 256,
   parameter int FRAME_HEIGHT = 224,
   parameter int HEADER_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_pixel_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_error_code,
   output logic [31:0] rsp_frame_number,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_brightness_level
);

   localparam int PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W = $clog2(PIXEL_COUNT);

   store_write_type wr;
   logic        clear_busy, accept, rd_pend_ff, out_free;
   logic [15:0] rd_data;
   logic [2:0]  p_status, p_err;
   logic [31:0] p_frames;
   logic [3:0]  bright_ff;
   logic        vld_ff;
   logic [2:0]  st_ff, err_ff;
   logic [31:0] frm_ff;
   logic [7:0]  r_ff, g_ff, b_ff;
   logic [4:0]  r5, b5;
   logic [5:0]  g6;

   assign out_free  = !vld_ff || rsp_ready;
   assign req_ready = !clear_busy && !rd_pend_ff && out_free;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   prdfd_store #(.PIXEL_COUNT(PIXEL_COUNT), .ADDR_W(ADDR_W)) u_store (
      .clock       (clock),
      .reset       (reset),
      .clear_start (accept && req_cmd == CMD_REWIND),
      .clear_busy  (clear_busy),
      .wr          (wr),
      .rd_addr     (req_pixel_index),
      .rd_data     (rd_data)
   );

   prdfd_parser #(
      .FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT), .HEADER_BYTES(HEADER_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .clear        (accept && req_cmd == CMD_REWIND),
      .byte_en      (accept && req_cmd == CMD_BYTE),
      .data_byte    (req_data_byte),
      .status       (p_status),
      .error_code   (p_err),
      .frame_number (p_frames),
      .wr           (wr)
   );

   assign r5 = rd_data[15:11];
   assign g6 = rd_data[10:5];
   assign b5 = rd_data[4:0];

   // Brightness register
   always_ff @(posedge clock) begin
      if (reset) bright_ff <= 4'd15;
      else if (csr_valid) bright_ff <= csr_brightness_level;
   end

   // Response register; a read is flagged in rd_pend_ff, then completes here
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= accept && req_cmd == CMD_READ;
         if (rd_pend_ff) vld_ff <= 1'b1;
         else if (accept && req_cmd != CMD_READ) vld_ff <= 1'b1;
         else if (rsp_ready) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         st_ff <= ST_READ;
         r_ff  <= scale_channel({r5, r5[4:2]}, bright_ff);
         g_ff  <= scale_channel({g6, g6[5:4]}, bright_ff);
         b_ff  <= scale_channel({b5, b5[4:2]}, bright_ff);
      end else if (accept) begin
         r_ff <= '0;
         g_ff <= '0;
         b_ff <= '0;
         case (req_cmd)
            CMD_BYTE:   st_ff <= p_status;
            CMD_REWIND: st_ff <= ST_TAKEN;
            CMD_READ:   st_ff <= ST_READ;
            default:    st_ff <= ST_IDLE;
         endcase
         if (req_cmd == CMD_REWIND) begin
            err_ff <= ERR_NONE;
            frm_ff <= '0;
         end else begin
            err_ff <= p_err;
            frm_ff <= p_frames;
         end
      end
   end

   assign rsp_valid        = vld_ff;
   assign rsp_status       = st_ff;
   assign rsp_error_code   = err_ff;
   assign rsp_frame_number = frm_ff;
   assign rsp_red          = r_ff;
   assign rsp_green        = g_ff;
   assign rsp_blue         = b_ff;

`ifndef NO_ASSERTIONS
   // No request is taken during the clearing sweep
   assert property (@(posedge clock) disable iff (reset) clear_busy |-> !req_ready)
      else $error("request taken while store clearing");
   // A pending read yields a response in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> vld_ff && st_ff == ST_READ)
      else $error("pixel read response missing");
   // Store writes only during stream bytes
   assert property (@(posedge clock) disable iff (reset)
      wr.wr_en |-> accept && req_cmd == CMD_BYTE)
      else $error("stray store write");
`endif

endmodule

FILE: tb/pixel_run_delta_frame_decoder_top_tb.sv
// Testbench for the pixel-run delta frame decoder: stream encoding, pixel reads and brightness.
`timescale 1ns / 100ps

module pixel_run_delta_frame_decoder_top_tb;
   import prdfd_pkg::*;

   localparam int FRAME_WIDTH  = 256;
   localparam int FRAME_HEIGHT = 224;
   localparam int HEADER_BYTES = 32;
   localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   // Record corruption modes
   localparam int MODE_CLEAN   = 0;
   localparam int MODE_HEADER  = 1;
   localparam int MODE_SMALL   = 2;
   localparam int MODE_RUNHDR  = 3;
   localparam int MODE_BEYOND  = 4;
   localparam int MODE_OVERRUN = 5;
   localparam int MODE_FLIP    = 6;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  error_code;
      logic [31:0] frame_number;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } decode_result_type;

   // Scoreboard: decoder model plus queue of awaited responses
   class decode_scoreboard;
      decode_result_type awaited[$];
      logic [15:0] frame_store[PIXELS];
      logic [2:0]  phase;
      int unsigned hdr_pos, shift_acc, bytes_left, runs_left, run_pos, run_left;
      int unsigned frames_done, frame_total;
      logic [2:0]  err;
      logic [3:0]  level;
      int          mismatches;
      bit          failed;

      function void clear_all();
         foreach (frame_store[i]) frame_store[i] = 16'h0000;
         phase = PH_HEADER;
         hdr_pos = 0; shift_acc = 0; bytes_left = 0; runs_left = 0;
         run_pos = 0; run_left = 0; frames_done = 0; frame_total = 0;
         err = ERR_NONE;
      endfunction

      function new();
         clear_all();
         level = 4'd15;
         mismatches = 0;
         failed = 0;
      endfunction

      function logic [2:0] flag_error(logic [2:0] code);
         err = code;
         return ST_ERROR;
      endfunction

      function logic [2:0] close_frame();
         frames_done++;
         hdr_pos = 0;
         shift_acc = 0;
         phase = (frames_done >= frame_total) ? PH_DONE : PH_REC_SIZE;
         return ST_FRAME;
      endfunction

      function logic [2:0] after_unit();
         hdr_pos = 0;
         shift_acc = 0;
         if (runs_left > 0) begin
            if (bytes_left < 4) return flag_error(ERR_RUNHDR);
            bytes_left -= 4;
            phase = PH_RUN_HDR;
            return ST_TAKEN;
         end
         if (bytes_left > 0) begin
            phase = PH_SKIP;
            return ST_TAKEN;
         end
         return close_frame();
      endfunction

      function logic [2:0] header_step(logic [7:0] b);
         int unsigned p;
         int unsigned v;
         bit ok;
         p = hdr_pos;
         if (p < 8) begin
            if (b != magic_byte(p[2:0])) return flag_error(ERR_HEADER);
         end else if (p < 32) begin
            shift_acc |= int'(b) << (8 * (p % 4));
            if (p % 4 == 3) begin
               v = shift_acc;
               if (p == 11) ok = (v == 1);
               else if (p == 15) ok = (v == FRAME_WIDTH);
               else if (p == 19) ok = (v == FRAME_HEIGHT);
               else ok = (v != 0);
               if (!ok) return flag_error(ERR_HEADER);
               if (p == 31) frame_total = v;
               shift_acc = 0;
            end
         end
         if (p >= 31 && p + 1 >= HEADER_BYTES) begin
            phase = PH_REC_SIZE;
            hdr_pos = 0;
            shift_acc = 0;
         end else begin
            hdr_pos = (p + 1) & 'h3F;
         end
         return ST_TAKEN;
      endfunction

      function logic [2:0] byte_step(logic [7:0] b);
         int unsigned p, start, len;
         p = hdr_pos % 4;
         if (err != ERR_NONE) return ST_ERROR;
         case (phase)
            PH_HEADER: return header_step(b);
            PH_REC_SIZE, PH_RUN_CNT, PH_RUN_HDR: begin
               shift_acc |= int'(b) << (8 * p);
               hdr_pos = p + 1;
               if (p != 3) return ST_TAKEN;
               hdr_pos = 0;
               if (phase == PH_REC_SIZE) begin
                  if (shift_acc < 4) return flag_error(ERR_SMALL);
                  bytes_left = shift_acc - 4;
                  shift_acc = 0;
                  phase = PH_RUN_CNT;
                  return ST_TAKEN;
               end
               if (phase == PH_RUN_CNT) begin
                  runs_left = shift_acc;
                  return after_unit();
               end
               start = shift_acc & 'hFFFF;
               len = shift_acc >> 16;
               runs_left--;
               shift_acc = 0;
               if (start + len > PIXELS) return flag_error(ERR_BEYOND);
               if (len * 2 > bytes_left) return flag_error(ERR_OVERRUN);
               bytes_left -= len * 2;
               if (len == 0) return after_unit();
               run_pos = start;
               run_left = len;
               phase = PH_PIXELS;
               return ST_TAKEN;
            end
            PH_PIXELS: begin
               if (hdr_pos % 2 == 0) begin
                  shift_acc = 32'(b);
                  hdr_pos = 1;
                  return ST_TAKEN;
               end
               if (run_pos < PIXELS) frame_store[run_pos] = {b, shift_acc[7:0]};
               run_pos++;
               run_left--;
               hdr_pos = 0;
               shift_acc = 0;
               if (run_left == 0) return after_unit();
               return ST_TAKEN;
            end
            PH_SKIP: begin
               if (bytes_left > 0) bytes_left--;
               if (bytes_left == 0) return close_frame();
               return ST_TAKEN;
            end
            default: return ST_IDLE;
         endcase
      endfunction

      function logic [7:0] dim(logic [7:0] c);
         return 8'((int'(c) * int'(level)) / 15);
      endfunction

      // Note an accepted request transaction and queue its response
      function void note_request(logic [1:0] cmd, logic [7:0] b, logic [15:0] idx);
         decode_result_type r;
         logic [15:0] c;
         r = '0;
         case (cmd)
            CMD_BYTE: r.status = byte_step(b);
            CMD_REWIND: begin
               clear_all();
               r.status = ST_TAKEN;
            end
            CMD_READ: begin
               c = (idx < PIXELS) ? frame_store[idx] : 16'h0000;
               r.red   = dim({c[15:11], c[15:13]});
               r.green = dim({c[10:5], c[10:9]});
               r.blue  = dim({c[4:0], c[4:2]});
               r.status = ST_READ;
            end
            default: r.status = ST_IDLE;
         endcase
         r.error_code = err;
         r.frame_number = frames_done;
         awaited.push_back(r);
      endfunction

      // Compare a response transaction with the oldest awaited one
      function void check_response(decode_result_type got);
         decode_result_type want;
         if (awaited.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %p", got);
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_BYTE;
   logic [7:0]  req_data_byte = 0;
   logic [15:0] req_pixel_index = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_error_code;
   logic [31:0] rsp_frame_number;
   logic [7:0]  rsp_red, rsp_green, rsp_blue;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [3:0]  csr_brightness_level = 4'd15;

   decode_scoreboard sb = new();
   bit     steady = 0;
   logic [7:0] stream_q[$];

   pixel_run_delta_frame_decoder_top #(
      .FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT), .HEADER_BYTES(HEADER_BYTES)
   ) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_data_byte(req_data_byte), .req_pixel_index(req_pixel_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_error_code(rsp_error_code), .rsp_frame_number(rsp_frame_number),
      .rsp_red(rsp_red), .rsp_green(rsp_green), .rsp_blue(rsp_blue),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_brightness_level(csr_brightness_level)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 14);
   end

   // Check responses mid-cycle, ahead of the accepting edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response({rsp_status, rsp_error_code, rsp_frame_number,
                            rsp_red, rsp_green, rsp_blue});
   end

   // Drive one request transaction and hold it until accepted
   task automatic send_request(logic [1:0] cmd, logic [7:0] b, logic [15:0] idx);
      bit ok;
      if (!steady && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_data_byte <= b;
      req_pixel_index <= idx;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
      sb.note_request(cmd, b, idx);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_level(logic [3:0] lvl);
      bit ok;
      drain();
      csr_valid <= 1'b1;
      csr_brightness_level <= lvl;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
      sb.level = lvl;
   endtask

   task automatic push_word(int unsigned w);
      for (int i = 0; i < 4; i++) stream_q.push_back(8'(w >> (8 * i)));
   endtask

   task automatic push_half(int unsigned h);
      stream_q.push_back(h[7:0]);
      stream_q.push_back(h[15:8]);
   endtask

   task automatic build_header(int unsigned count);
      for (int i = 0; i < 8; i++) stream_q.push_back(magic_byte(3'(i)));
      push_word(1);
      push_word(FRAME_WIDTH);
      push_word(FRAME_HEIGHT);
      push_word($urandom_range(60, 1));
      push_word($urandom_range(2) == 0 ? 32'hFFFF_FFFF : $urandom_range(9, 1));
      push_word(count);
   endtask

   // Append one record; the mode picks which fault, if any, it carries
   task automatic build_record(int mode);
      int unsigned nruns, extra, size, runs_field, last_len;
      int unsigned lens[4];
      int unsigned starts[4];
      nruns = $urandom_range(3, (mode == MODE_CLEAN || mode == MODE_FLIP) ? 0 : 1);
      extra = (mode == MODE_RUNHDR) ? 0 : $urandom_range(3);
      size = 4 + extra;
      for (int i = 0; i < nruns; i++) begin
         lens[i] = $urandom_range(4);
         if ($urandom_range(3) == 0) starts[i] = PIXELS - lens[i];
         else starts[i] = $urandom_range(63);
         size += 4 + 2 * lens[i];
      end
      last_len = lens[nruns > 0 ? nruns - 1 : 0];
      runs_field = nruns;
      if (mode == MODE_RUNHDR) runs_field = nruns + 1;
      if (mode == MODE_BEYOND) begin
         lens[nruns - 1] = last_len + 1;
         starts[nruns - 1] = PIXELS - last_len;
      end
      if (mode == MODE_OVERRUN) begin
         lens[nruns - 1] = last_len + extra + 1;
      end
      if (mode == MODE_SMALL) size = $urandom_range(3);
      push_word(size);
      push_word(runs_field);
      for (int i = 0; i < nruns; i++) begin
         push_half(starts[i]);
         push_half(lens[i]);
         for (int k = 0; k < lens[i]; k++) push_half($urandom_range(16'hFFFF));
      end
      for (int i = 0; i < extra; i++) stream_q.push_back(8'($urandom_range(255)));
   endtask

   // Play the stream out, with pixel reads and stray commands mixed in
   task automatic play_stream(int read_pct);
      logic [7:0] b;
      while (stream_q.size() != 0) begin
         if ($urandom_range(99) < read_pct) begin
            if ($urandom_range(3) == 0)
               send_request(CMD_READ, 8'($urandom_range(255)),
                            16'($urandom_range(16'hFFFF)));
            else if ($urandom_range(1) == 0)
               send_request(CMD_READ, 8'($urandom_range(255)), 16'($urandom_range(63)));
            else
               send_request(CMD_READ, 8'($urandom_range(255)),
                            16'(PIXELS - $urandom_range(5, 1)));
         end else if ($urandom_range(99) == 0) begin
            send_request(CMD_UNKNOWN, 8'($urandom_range(255)),
                         16'($urandom_range(16'hFFFF)));
         end else begin
            b = stream_q.pop_front();
            send_request(CMD_BYTE, b, 16'($urandom_range(16'hFFFF)));
         end
      end
   endtask

   initial begin
      int mode, nframes, pos;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: clean stream with edge pixels, then reads and stray commands
      write_level(4'd15);
      build_header(1);
      push_word(4 + 4 + 2 + 4 + 2);
      push_word(2);
      push_half(0); push_half(1); push_half(16'hFFFF);
      push_half(PIXELS - 1); push_half(1); push_half(16'h0000);
      play_stream(0);
      send_request(CMD_BYTE, 8'hFF, 16'h0000);
      send_request(CMD_READ, 8'h00, 16'd0);
      send_request(CMD_READ, 8'h00, 16'(PIXELS - 1));
      send_request(CMD_READ, 8'h00, 16'(PIXELS));
      send_request(CMD_READ, 8'h00, 16'hFFFF);
      send_request(CMD_UNKNOWN, 8'hFF, 16'hFFFF);
      write_level(4'd0);
      send_request(CMD_READ, 8'h00, 16'd0);
      write_level(4'd7);
      send_request(CMD_READ, 8'h00, 16'd0);

      // Random episodes, each opened by a rewind
      for (int ep = 0; ep < 5; ep++) begin
         drain();
         write_level(ep == 0 ? 4'd15 : ep == 1 ? 4'd1 : 4'($urandom_range(15)));
         steady = (ep == 2);
         send_request(CMD_REWIND, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)));
         mode = (ep == 0) ? MODE_CLEAN : $urandom_range(MODE_FLIP);
         nframes = $urandom_range(6, 3);
         if (mode == MODE_HEADER) begin
            build_header(nframes);
            pos = $urandom_range(31);
            stream_q[pos] = stream_q[pos] ^ 8'($urandom_range(255, 1));
            build_record(MODE_CLEAN);
         end else begin
            build_header(nframes);
            for (int f = 0; f < nframes; f++)
               build_record((f == nframes - 1 && mode != MODE_FLIP) ? mode : MODE_CLEAN);
            if (mode == MODE_FLIP) begin
               pos = $urandom_range(stream_q.size() - 1, 32);
               stream_q[pos] = stream_q[pos] ^ 8'($urandom_range(255, 1));
            end
         end
         for (int i = 0; i < 4; i++) stream_q.push_back(8'($urandom_range(255)));
         play_stream(15);
         repeat (20) send_request(CMD_READ, 8'h00, 16'($urandom_range(16'hFFFF)));
      end
      steady = 0;

      drain();
      repeat (20) @(posedge clock);
      if (!sb.failed && sb.awaited.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Timeout guard
   initial begin
      #4000000;
      $display("Verification failed");
      $finish;
   end

endmodule
